// ----- design/itp_pkg.sv -----
package itp_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POS   = 8'h24;
    localparam logic [7:0] CH_NEG   = 8'h7E;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NULL  = 8'h00;

    localparam logic [2:0] PRIO_OPEN  = 3'd0;
    localparam logic [2:0] PRIO_CLOSE = 3'd1;
    localparam logic [2:0] PRIO_ADD   = 3'd2;
    localparam logic [2:0] PRIO_MUL   = 3'd3;
    localparam logic [2:0] PRIO_POW   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BRACKET  = 2'd1;
    localparam logic [1:0] ST_DOUBLE   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_expr;
        logic       space_first;
        logic       unary;
        logic       is_digit;
        logic       is_op;
        logic [2:0] cprio;
        logic       mismatch;
        logic       double_err;
    } item_t;

    function automatic logic char_is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic char_is_op(input logic [7:0] c);
        return c inside {CH_OPEN, CH_CLOSE, CH_PLUS, CH_MINUS, CH_MUL, CH_DIV,
                         CH_POS, CH_NEG, CH_POW};
    endfunction

    function automatic logic [2:0] op_prio(input logic [7:0] c);
        logic [2:0] p;
        case (c)
            CH_CLOSE: p = PRIO_CLOSE;
            CH_PLUS, CH_MINUS: p = PRIO_ADD;
            CH_MUL, CH_DIV, CH_POS, CH_NEG: p = PRIO_MUL;
            CH_POW: p = PRIO_POW;
            default: p = PRIO_OPEN;
        endcase
        return p;
    endfunction

endpackage

// ----- design/itp_front.sv -----
module itp_front import itp_pkg::*; #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    logic [7:0]             prev_char_reg, prev_char_next;
    logic                   at_start_reg, at_start_next;
    logic [COUNT_WIDTH-1:0] open_count_reg, open_count_next;
    logic [COUNT_WIDTH-1:0] close_count_reg, close_count_next;
    logic                   double_reg, double_next;
    logic                   accept;
    logic                   prev_addsub;
    logic                   dbl_now;

    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign accept   = s_tvalid && q_ready;

    assign prev_addsub = (prev_char_reg == CH_PLUS) || (prev_char_reg == CH_MINUS);
    assign dbl_now = !at_start_reg && prev_addsub &&
                     (s_tdata inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV});

    always_comb begin
        q_item.ch          = s_tdata;
        q_item.end_expr    = s_tlast;
        q_item.space_first = !at_start_reg && char_is_digit(prev_char_reg) &&
                             (s_tlast || !char_is_digit(s_tdata));
        q_item.unary       = at_start_reg || prev_addsub || (prev_char_reg == CH_OPEN);
        q_item.is_digit    = !s_tlast && char_is_digit(s_tdata);
        q_item.is_op       = !s_tlast && char_is_op(s_tdata);
        q_item.cprio       = op_prio(s_tdata);
        q_item.mismatch    = open_count_reg != close_count_reg;
        q_item.double_err  = double_reg;
    end

    always_comb begin
        prev_char_next   = prev_char_reg;
        at_start_next    = at_start_reg;
        open_count_next  = open_count_reg;
        close_count_next = close_count_reg;
        double_next      = double_reg;
        if (accept) begin
            if (s_tlast) begin
                prev_char_next   = CH_NULL;
                at_start_next    = 1'b1;
                open_count_next  = '0;
                close_count_next = '0;
                double_next      = 1'b0;
            end else begin
                prev_char_next = s_tdata;
                at_start_next  = 1'b0;
                double_next    = double_reg || dbl_now;
                if (s_tdata == CH_OPEN) begin
                    open_count_next = open_count_reg + COUNT_WIDTH'(1);
                end
                if (s_tdata == CH_CLOSE) begin
                    close_count_next = close_count_reg + COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_char_reg   <= CH_NULL;
            at_start_reg    <= 1'b1;
            open_count_reg  <= '0;
            close_count_reg <= '0;
            double_reg      <= 1'b0;
        end else begin
            prev_char_reg   <= prev_char_next;
            at_start_reg    <= at_start_next;
            open_count_reg  <= open_count_next;
            close_count_reg <= close_count_next;
            double_reg      <= double_next;
        end
    end

endmodule

// ----- design/itp_queue.sv -----
module itp_queue import itp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_pop,
    output item_t out_item
);

    item_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               wr_en;
    logic               rd_en;

    assign in_ready  = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_item  = entry_mem[rptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_pop && out_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (wr_en) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (rd_en) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (rd_en && !wr_en) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- design/itp_back.sv -----
module itp_back import itp_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_pop,
    input  item_t      q_item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [3:0] m_tuser
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [5:0] {
        S_LEAD     = 6'b000001,
        S_BODY     = 6'b000010,
        S_POPOP    = 6'b000100,
        S_POPSP    = 6'b001000,
        S_FLUSH    = 6'b010000,
        S_FLUSHSP  = 6'b100000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [7:0]        stack_mem [STACK_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  count_m1;
    logic              overflow_reg, overflow_next;
    logic              popped_reg, popped_next;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;
    logic [3:0]        m_tuser_reg;

    logic              out_free, step;
    logic [7:0]        top;
    logic              stack_empty, stack_full, will_pop;
    logic [7:0]        push_val;
    logic              run_body, finish;
    logic              dec, push_en, clear;
    logic [7:0]        push_byte;
    logic              emit, e_valid, e_last, e_done;
    logic [7:0]        e_byte;
    logic [1:0]        e_status;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign step        = q_valid && out_free;
    assign count_m1    = count_reg - CNT_W'(1);
    assign top         = stack_mem[count_m1[IDX_W-1:0]];
    assign stack_empty = count_reg == '0;
    assign stack_full  = count_reg == CNT_W'(STACK_DEPTH);

    always_comb begin
        will_pop = 1'b0;
        if (!stack_empty && q_item.is_op) begin
            if (q_item.cprio == PRIO_CLOSE) begin
                will_pop = top != CH_OPEN;
            end else if (q_item.cprio >= PRIO_ADD) begin
                will_pop = op_prio(top) >= q_item.cprio;
            end
        end
    end

    always_comb begin
        if (q_item.unary && q_item.ch == CH_MINUS) begin
            push_val = CH_NEG;
        end else if (q_item.unary && q_item.ch == CH_PLUS) begin
            push_val = CH_POS;
        end else begin
            push_val = q_item.ch;
        end
    end

    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        popped_next   = popped_reg;
        run_body      = 1'b0;
        finish        = 1'b0;
        dec           = 1'b0;
        push_en       = 1'b0;
        push_byte     = push_val;
        clear         = 1'b0;
        q_pop         = 1'b0;
        emit          = 1'b0;
        e_byte        = CH_SPACE;
        e_valid       = 1'b1;
        e_last        = 1'b0;
        e_done        = 1'b0;
        e_status      = ST_OK;

        if (step) begin
            case (state_reg)
                S_LEAD: begin
                    if (q_item.end_expr) begin
                        emit       = q_item.space_first;
                        state_next = S_FLUSH;
                    end else if (q_item.space_first) begin
                        emit       = 1'b1;
                        e_last     = !q_item.is_digit && !will_pop;
                        state_next = S_BODY;
                    end else begin
                        run_body = 1'b1;
                    end
                end
                S_BODY: begin
                    run_body = 1'b1;
                end
                S_POPOP: begin
                    emit       = 1'b1;
                    e_byte     = top;
                    dec        = 1'b1;
                    state_next = S_POPSP;
                end
                S_POPSP: begin
                    emit = 1'b1;
                    if (will_pop) begin
                        state_next = S_POPOP;
                    end else begin
                        e_last = 1'b1;
                        finish = 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (stack_empty) begin
                        emit    = 1'b1;
                        e_byte  = CH_NULL;
                        e_valid = 1'b0;
                        e_last  = 1'b1;
                        e_done  = 1'b1;
                        if (q_item.mismatch) begin
                            e_status = ST_BRACKET;
                        end else if (q_item.double_err) begin
                            e_status = ST_DOUBLE;
                        end else if (overflow_reg) begin
                            e_status = ST_OVERFLOW;
                        end
                        clear         = 1'b1;
                        overflow_next = 1'b0;
                        popped_next   = 1'b0;
                        q_pop         = 1'b1;
                        state_next    = S_LEAD;
                    end else if (top != CH_OPEN) begin
                        emit       = 1'b1;
                        e_byte     = top;
                        dec        = 1'b1;
                        state_next = S_FLUSHSP;
                    end else begin
                        dec = 1'b1;
                    end
                end
                S_FLUSHSP: begin
                    emit       = 1'b1;
                    state_next = S_FLUSH;
                end
                default: begin
                    state_next = S_LEAD;
                end
            endcase
        end

        if (run_body) begin
            if (q_item.is_digit) begin
                emit       = 1'b1;
                e_byte     = q_item.ch;
                e_last     = 1'b1;
                q_pop      = 1'b1;
                state_next = S_LEAD;
            end else if (q_item.is_op && will_pop) begin
                emit        = 1'b1;
                e_byte      = top;
                dec         = 1'b1;
                popped_next = 1'b1;
                state_next  = S_POPSP;
            end else if (q_item.is_op) begin
                finish = 1'b1;
            end else begin
                q_pop      = 1'b1;
                state_next = S_LEAD;
            end
        end

        if (finish) begin
            q_pop       = 1'b1;
            popped_next = 1'b0;
            state_next  = S_LEAD;
            if (q_item.cprio == PRIO_CLOSE) begin
                if (!stack_empty && top == CH_OPEN) begin
                    dec = 1'b1;
                end else if (stack_empty && !popped_reg) begin
                    push_en   = 1'b1;
                    push_byte = CH_CLOSE;
                end
            end else if (stack_full) begin
                overflow_next = 1'b1;
            end else begin
                push_en = 1'b1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (dec) begin
            count_next = count_m1;
        end else if (push_en) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[count_reg[IDX_W-1:0]] <= push_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= e_byte;
            m_tlast_reg <= e_last;
            m_tuser_reg <= {e_status, e_done, e_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LEAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            popped_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            popped_reg   <= popped_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/infix_to_postfix_converter.sv -----
// Flow: an accepted request enters the queue; the back end registers each result it gives in the
// output register, and an end request with no trailing space first moves to the flush state.
// Results leave at one result per cycle while m_tready is high; steps that emit nothing (a push,
// an ignored character, a dropped open bracket, the first step of an end request with no trailing
// space) hold them back, and each popped operator emits its byte and then a space.
// Reset: aresetn is synchronous and active low; it empties the queue and the stack.
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int COUNT_WIDTH = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // ch
    input  logic       s_tlast,  // end_expr
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // out_byte
    output logic       m_tlast,  // run_last
    output logic [3:0] m_tuser   // byte_valid, expr_done, status[1:0]
);

    item_t fq_item;
    item_t qb_item;
    logic  fq_valid;
    logic  fq_ready;
    logic  qb_valid;
    logic  qb_pop;

    itp_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    itp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_item  (fq_item),
        .out_valid(qb_valid),
        .out_pop  (qb_pop),
        .out_item (qb_item)
    );

    itp_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_pop   (qb_pop),
        .q_item  (qb_item),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
